[rtl/bms_pkg.sv]
// Shared constants and codes for the bookmark set block.
`default_nettype none

package bms_pkg;

    // Capacity of the bookmark list.
    localparam int MARK_COUNT = 32;

    // Widths of the transaction fields.
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 8;
    localparam int COUNT_W = 6;

    // Internal widths that follow from the capacity.
    localparam int CNT_W  = $clog2(MARK_COUNT + 1);
    localparam int ADDR_W = (MARK_COUNT > 1) ? $clog2(MARK_COUNT) : 1;
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    // Operation codes carried on func.
    localparam logic FUNC_ADD = 1'b0;
    localparam logic FUNC_DEL = 1'b1;

endpackage

`default_nettype wire

[rtl/bookmark_set_insert_delete.sv]
// Top level of the bookmark set: request sequencer around the entry memory.
//
// The block keeps an ordered list of up to MARK_COUNT signed 32-bit bookmarks in one
// synchronous RAM, with the entry count in a register. A transaction is taken when start
// is high and busy is low; its result appears on ok and count, marked by done for exactly
// one cycle, and the receiver cannot stall it. A rejected request (add to a full
// list, delete from an empty list or at an index not below the count) answers in the
// cycle after it is taken. An add scans every stored entry through the single RAM read
// port, one entry a cycle, and answers as soon as a duplicate is found or once every
// entry has been compared. A delete moves the later entries down one place through the same
// port, reading one and writing one each cycle, and answers when no entry is left to move.
// No new transaction is taken until the current one has answered; start may be raised
// again in the cycle that done is shown. After reset the list is empty at once; no clearing
// pass is needed because entries at or above the count are never read.
`default_nettype none

module bookmark_set_insert_delete (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         func,
    input  wire logic signed [bms_pkg::VAL_W-1:0] value,
    input  wire logic [bms_pkg::IDX_W-1:0]    index,
    output logic                              done,
    output logic                              ok,
    output logic [bms_pkg::COUNT_W-1:0]       count
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_SHIFT = 3'b100
    } state_t;

    state_t                         state_reg, state_next;
    logic [bms_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [bms_pkg::CNT_W-1:0]      ptr_reg, ptr_next;
    logic [bms_pkg::ADDR_W-1:0]     dst_reg, dst_next;
    logic                           pend_reg, pend_next;
    logic [bms_pkg::VAL_W-1:0]      val_reg, val_next;
    logic                           done_reg, done_next;
    logic                           ok_reg, ok_next;

    logic                           mem_we;
    logic [bms_pkg::ADDR_W-1:0]     mem_waddr;
    logic [bms_pkg::VAL_W-1:0]      mem_wdata;
    logic [bms_pkg::ADDR_W-1:0]     mem_raddr;
    logic [bms_pkg::VAL_W-1:0]      mem_rdata;

    logic                           rd_more;
    logic                           full;
    logic                           idx_bad;

    // Entry storage.
    bms_ram #(
        .WIDTH (bms_pkg::VAL_W),
        .DEPTH (bms_pkg::MARK_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Request checks against the current count.
    assign rd_more = (ptr_reg < cnt_reg);
    assign full    = (cnt_reg >= bms_pkg::CNT_W'(bms_pkg::MARK_COUNT));
    assign idx_bad = (bms_pkg::CMP_W'(index) >= bms_pkg::CMP_W'(cnt_reg));

    // Sequencer: duplicate scan for add, shift-down for delete.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ptr_next   = ptr_reg;
        dst_next   = dst_reg;
        pend_next  = 1'b0;
        val_next   = val_reg;
        done_next  = 1'b0;
        ok_next    = ok_reg;
        mem_we     = 1'b0;
        mem_waddr  = dst_reg;
        mem_wdata  = mem_rdata;
        mem_raddr  = ptr_reg[bms_pkg::ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (func == bms_pkg::FUNC_ADD)
                    begin
                        if (full)
                        begin
                            done_next = 1'b1;
                            ok_next   = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                            ptr_next   = '0;
                            val_next   = value;
                        end
                    end
                    else
                    begin
                        if (idx_bad)
                        begin
                            done_next = 1'b1;
                            ok_next   = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_SHIFT;
                            ptr_next   = bms_pkg::CNT_W'(index) + 1'b1;
                            dst_next   = bms_pkg::ADDR_W'(index);
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // Compare the entry read in the previous cycle.
                if (pend_reg && (mem_rdata == val_reg))
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    ok_next    = 1'b0;
                end
                else if (!pend_reg && !rd_more)
                begin
                    // No duplicate: append at the end of the list.
                    mem_we     = 1'b1;
                    mem_waddr  = cnt_reg[bms_pkg::ADDR_W-1:0];
                    mem_wdata  = val_reg;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                end
                else if (rd_more)
                begin
                    ptr_next  = ptr_reg + 1'b1;
                    pend_next = 1'b1;
                end
            end

            ST_SHIFT:
            begin
                // Write the entry read in the previous cycle one place down.
                if (pend_reg)
                begin
                    mem_we   = 1'b1;
                    dst_next = dst_reg + 1'b1;
                end
                if (rd_more)
                begin
                    ptr_next  = ptr_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            ok_reg    <= ok_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        dst_reg <= dst_next;
        val_reg <= val_next;
    end

    // Result ports.
    assign busy  = (state_reg != ST_IDLE);
    assign done  = done_reg;
    assign ok    = ok_reg;
    assign count = bms_pkg::COUNT_W'(cnt_reg);

endmodule

`default_nettype wire

[rtl/bms_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM with registered read.
`default_nettype none

module bms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/bms_checker.sv]
// Port-level checker for the bookmark set, bound to the top level.
`default_nettype none

module bms_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic                              done,
    input wire logic                              ok,
    input wire logic [bms_pkg::COUNT_W-1:0]       count
);

    // A taken transaction either answers at once or makes the block busy.
    a_take_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("taken transaction neither answered nor marked busy");

    // The block is free again whenever it answers.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    // A rejected transaction leaves the count unchanged.
    a_reject_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> $stable(count))
        else $error("count changed on a rejected transaction");

    // The count never exceeds the capacity.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((bms_pkg::MARK_COUNT > 63) ||
                  (count <= bms_pkg::COUNT_W'(bms_pkg::MARK_COUNT))))
        else $error("count above capacity");

endmodule

bind bookmark_set_insert_delete bms_checker u_bms_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ok    (ok),
    .count (count)
);

`default_nettype wire

[dv/tb_bookmark_set_insert_delete.sv]
// Self-checking testbench for the bookmark set: directed table, then random add/delete traffic.
`default_nettype none

module tb_bookmark_set_insert_delete;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1550;
    localparam int SETTLE_CYCLES = bms_pkg::MARK_COUNT + 8;
    localparam logic signed [bms_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [bms_pkg::VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // One answer of the block: success flag and the count after the request.
    typedef struct packed {
        logic                        ok;
        logic [bms_pkg::COUNT_W-1:0] count;
    } mark_answer_t;

    // One row of the directed table; typed rows carry their answer written out.
    typedef struct {
        logic                              func;
        logic signed [bms_pkg::VAL_W-1:0]  value;
        logic [bms_pkg::IDX_W-1:0]         index;
        bit                                typed;
        mark_answer_t                      answer;
    } directed_row_t;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic                              func;
    logic signed [bms_pkg::VAL_W-1:0]  value;
    logic [bms_pkg::IDX_W-1:0]         index;
    logic                              done;
    logic                              ok;
    logic [bms_pkg::COUNT_W-1:0]       count;

    // Shadow copy of the bookmark list kept by the predictor.
    logic signed [bms_pkg::VAL_W-1:0]  shadow_marks [bms_pkg::MARK_COUNT];
    int                                shadow_total;

    // Answers owed by the block, oldest first.
    mark_answer_t                      awaited_answers [$];

    int mismatch_count;
    int answers_checked;
    int adds_taken, deletes_taken, full_rejects, duplicate_rejects, delete_rejects;
    int full_reached;

    bookmark_set_insert_delete u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .func  (func),
        .value (value),
        .index (index),
        .done  (done),
        .ok    (ok),
        .count (count)
    );

    always #2 clk = ~clk;

    // Apply one request to the shadow list and return the answer it should give.
    function automatic mark_answer_t predict_answer(
        input logic                              f,
        input logic signed [bms_pkg::VAL_W-1:0]  v,
        input logic [bms_pkg::IDX_W-1:0]         idx);
        mark_answer_t res;
        bit           found;
        res.ok = 1'b0;
        found  = 1'b0;
        if (f == bms_pkg::FUNC_ADD) begin
            if (shadow_total >= bms_pkg::MARK_COUNT) begin
                full_rejects++;
            end
            else begin
                for (int i = 0; i < shadow_total; i++)
                    if (shadow_marks[i] == v)
                        found = 1'b1;
                if (found) begin
                    duplicate_rejects++;
                end
                else begin
                    shadow_marks[shadow_total] = v;
                    shadow_total++;
                    adds_taken++;
                    res.ok = 1'b1;
                    if (shadow_total == bms_pkg::MARK_COUNT)
                        full_reached++;
                end
            end
        end
        else begin
            if (shadow_total == 0 || int'(idx) >= shadow_total) begin
                delete_rejects++;
            end
            else begin
                for (int i = int'(idx); i + 1 < shadow_total; i++)
                    shadow_marks[i] = shadow_marks[i + 1];
                shadow_total--;
                shadow_marks[shadow_total] = '0;
                deletes_taken++;
                res.ok = 1'b1;
            end
        end
        res.count = bms_pkg::COUNT_W'(shadow_total);
        return res;
    endfunction

    // Present one request after a gap, wait for it to be taken, then record its answer.
    task automatic send_request(input logic f, input logic signed [bms_pkg::VAL_W-1:0] v,
                                input logic [bms_pkg::IDX_W-1:0] idx, input int gap,
                                input bit typed, input mark_answer_t typed_answer);
        mark_answer_t predicted;
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        func  <= f;
        value <= v;
        index <= idx;
        do @(posedge clk); while (busy);
        predicted = predict_answer(f, v, idx);
        awaited_answers.push_back(typed ? typed_answer : predicted);
    endtask

    // Hold the sender off until the block has answered everything it owes.
    task automatic wait_for_answers();
        while (awaited_answers.size() != 0)
            @(posedge clk);
    endtask

    task automatic flag_mismatch(input string what, input mark_answer_t want);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH (%s) at %0t: expected ok=%0b count=%0d, got ok=%0b count=%0d",
                     what, $time, want.ok, want.count, ok, count);
    endtask

    // Check every answer against the oldest one owed.
    always @(posedge clk)
    begin : answer_check
        mark_answer_t want;
        if (rst_n && done) begin
            if (awaited_answers.size() == 0) begin
                flag_mismatch("answer with no request outstanding", '0);
            end
            else begin
                want = awaited_answers.pop_front();
                answers_checked++;
                if (ok !== want.ok || count !== want.count)
                    flag_mismatch("wrong answer", want);
            end
        end
    end

    // Stimulus: reset, directed table, then random bursts of adds and deletes.
    initial
    begin : stimulus
        directed_row_t                     rows [$];
        int                                sent;
        int                                mode;
        int                                burst;
        int                                pick;
        int                                gap;
        bit                                calm;
        bit                                do_add;
        logic signed [bms_pkg::VAL_W-1:0]  v;
        logic [bms_pkg::IDX_W-1:0]         idx;

        rst_n = 1'b0;
        start = 1'b0;
        func  = bms_pkg::FUNC_ADD;
        value = '0;
        index = '0;
        shadow_total = 0;
        for (int i = 0; i < bms_pkg::MARK_COUNT; i++)
            shadow_marks[i] = '0;
        mismatch_count = 0;
        answers_checked = 0;
        adds_taken = 0;
        deletes_taken = 0;
        full_rejects = 0;
        duplicate_rejects = 0;
        delete_rejects = 0;
        full_reached = 0;
        sent = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed cases: empty-list deletes, extreme values, duplicates, bad indexes,
        // deletes at the head, the tail and the middle, and re-adding removed values.
        rows.push_back('{bms_pkg::FUNC_DEL, 32'sh1234_5678, 8'd0,   1'b1, '{1'b0, 6'd0}});
        rows.push_back('{bms_pkg::FUNC_DEL, 32'sh0,         8'd255, 1'b1, '{1'b0, 6'd0}});
        rows.push_back('{bms_pkg::FUNC_ADD, VAL_MIN,        8'd0,   1'b1, '{1'b1, 6'd1}});
        rows.push_back('{bms_pkg::FUNC_ADD, VAL_MIN,        8'd0,   1'b1, '{1'b0, 6'd1}});
        rows.push_back('{bms_pkg::FUNC_ADD, VAL_MAX,        8'd255, 1'b1, '{1'b1, 6'd2}});
        rows.push_back('{bms_pkg::FUNC_ADD, 32'sh0,         8'd0,   1'b1, '{1'b1, 6'd3}});
        rows.push_back('{bms_pkg::FUNC_ADD, -32'sd1,        8'd0,   1'b1, '{1'b1, 6'd4}});
        rows.push_back('{bms_pkg::FUNC_ADD, 32'sh7FFF_FFFE, 8'd0,   1'b1, '{1'b1, 6'd5}});
        rows.push_back('{bms_pkg::FUNC_ADD, -32'sd1,        8'd0,   1'b1, '{1'b0, 6'd5}});
        rows.push_back('{bms_pkg::FUNC_DEL, 32'sh0,         8'd5,   1'b1, '{1'b0, 6'd5}});
        rows.push_back('{bms_pkg::FUNC_DEL, -32'sd1,        8'd255, 1'b1, '{1'b0, 6'd5}});
        rows.push_back('{bms_pkg::FUNC_DEL, 32'sh0,         8'd0,   1'b1, '{1'b1, 6'd4}});
        rows.push_back('{bms_pkg::FUNC_ADD, VAL_MIN,        8'd0,   1'b1, '{1'b1, 6'd5}});
        rows.push_back('{bms_pkg::FUNC_DEL, 32'sh0,         8'd4,   1'b1, '{1'b1, 6'd4}});
        rows.push_back('{bms_pkg::FUNC_DEL, 32'sh0,         8'd1,   1'b1, '{1'b1, 6'd3}});
        rows.push_back('{bms_pkg::FUNC_ADD, 32'sh0,         8'd0,   1'b1, '{1'b1, 6'd4}});
        rows.push_back('{bms_pkg::FUNC_DEL, 32'sh0,         8'd3,   1'b1, '{1'b1, 6'd3}});
        rows.push_back('{bms_pkg::FUNC_ADD, 32'sh5555_5555, 8'hAA,  1'b0, '0});
        rows.push_back('{bms_pkg::FUNC_ADD, 32'shAAAA_AAAA, 8'h55,  1'b0, '0});
        rows.push_back('{bms_pkg::FUNC_DEL, 32'sh5555_5555, 8'hAA,  1'b0, '0});
        rows.push_back('{bms_pkg::FUNC_DEL, 32'shAAAA_AAAA, 8'h01,  1'b0, '0});
        rows.push_back('{bms_pkg::FUNC_ADD, 32'shAAAA_AAAA, 8'h00,  1'b0, '0});
        foreach (rows[r])
        begin
            send_request(rows[r].func, rows[r].value, rows[r].index, $urandom_range(0, 7),
                         rows[r].typed, rows[r].answer);
            sent++;
        end

        // Let the block drain completely once before the random part.
        @(negedge clk);
        start <= 1'b0;
        wait_for_answers();

        // Random bursts: filling, draining or mixed, so the list often reaches full and empty.
        while (sent < ITEM_TARGET)
        begin
            mode  = $urandom_range(0, 3);
            burst = $urandom_range(8, 48);
            calm  = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0) begin
                @(negedge clk);
                start <= 1'b0;
                wait_for_answers();
            end
            for (int k = 0; k < burst && sent < ITEM_TARGET; k++)
            begin
                case (mode)
                    0:       do_add = ($urandom_range(0, 9) != 0);
                    1:       do_add = ($urandom_range(0, 19) < 3);
                    default: do_add = ($urandom_range(0, 1) == 0);
                endcase
                v   = $urandom;
                idx = bms_pkg::IDX_W'($urandom_range(0, 255));
                if (do_add) begin
                    pick = $urandom_range(0, 9);
                    if (pick >= 5 && pick <= 6)
                        v = $signed($urandom_range(0, 15)) - 8;
                    else if (pick == 7)
                        case ($urandom_range(0, 3))
                            0:       v = VAL_MIN;
                            1:       v = VAL_MAX;
                            2:       v = '0;
                            default: v = -1;
                        endcase
                    else if (pick >= 8 && shadow_total > 0)
                        v = shadow_marks[$urandom_range(0, shadow_total - 1)];
                end
                else begin
                    pick = $urandom_range(0, 9);
                    if (pick <= 6)
                        idx = (shadow_total > 0)
                            ? bms_pkg::IDX_W'($urandom_range(0, shadow_total - 1))
                            : '0;
                    else if (pick == 7)
                        idx = bms_pkg::IDX_W'(shadow_total);
                end
                gap = calm ? 0 : $urandom_range(0, 7);
                send_request(do_add ? bms_pkg::FUNC_ADD : bms_pkg::FUNC_DEL, v, idx, gap,
                             1'b0, '0);
                sent++;
            end
        end

        // Wind down: stop requesting, collect the last answers and let the block settle.
        @(negedge clk);
        start <= 1'b0;
        wait_for_answers();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Requests sent: %0d, answers checked: %0d, mismatches: %0d, list filled %0d",
                 sent, answers_checked, mismatch_count, full_reached);
        $display("Adds %0d, deletes %0d, full-list rejects %0d, duplicate rejects %0d, %s%0d",
                 adds_taken, deletes_taken, full_rejects, duplicate_rejects,
                 "bad deletes ", delete_rejects);
        if (mismatch_count == 0 && awaited_answers.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin : watchdog
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

[bookmark_set_insert_delete.f]
rtl/bms_pkg.sv
rtl/bms_ram.sv
rtl/bookmark_set_insert_delete.sv
rtl/bms_checker.sv
dv/tb_bookmark_set_insert_delete.sv
